@@ sv/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the breath and slide MIDI event generator.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_QUANTIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_ON   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_FULL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_LAST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_NONE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEND_THR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CC_INTERVAL = 3'd7;

  // Message kinds
  localparam logic [2:0] MSG_NOTE_OFF = 3'd0;
  localparam logic [2:0] MSG_NOTE_ON  = 3'd1;
  localparam logic [2:0] MSG_BEND     = 3'd2;
  localparam logic [2:0] MSG_CC       = 3'd3;
  localparam logic [2:0] MSG_ALL_OFF  = 3'd4;

  localparam logic [6:0] CC_BREATH = 7'd2;
  localparam logic [6:0] CC_X      = 7'd16;
  localparam logic [6:0] CC_Y      = 7'd17;

  localparam logic [13:0] NEUTRAL_BEND = 14'd8191;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] breath_sample;
    logic [SAMPLE_BITS-1:0] slide_sample;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [3:0]             overtone_keys;
    logic                   meta_pressed;
    logic                   panic_pressed;
    logic [30:0]            time_ms;
  } scan_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [3:0]  channel;
    logic [6:0]  key_or_controller;
    logic [13:0] value;
    logic        last;
  } msg_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic eval;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mask_empty;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ sv/bsm_div.sv @@
// ----------------------------------------------------------------------------
// bsm_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsm_div #(
  parameter int NW = 23,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      shifted;
  logic             fits;

  assign shifted = {rem, quo[NW-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign busy    = cnt != '0;

  // Count down the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Shift, compare and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (busy) begin
      rem <= fits ? DW'(shifted - {1'b0, dsr}) : shifted[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end
endmodule

@@ sv/bsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer: capture a scan, run the mapping divisions, evaluate, emit.
// ----------------------------------------------------------------------------
module bsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bsm_pkg::ctrl_status_t status,
  output bsm_pkg::ctrl_cmd_t    cmd
);
  import bsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV   = 5'b00100,
    S_EVAL  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

  // Decode commands and advance
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.mask_empty) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ sv/bsm_datapath.sv @@
// ----------------------------------------------------------------------------
// bsm_datapath
// Configuration, mapping arithmetic, note state and the message output register.
// ----------------------------------------------------------------------------
module bsm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]         cfg_data,
  input  bsm_pkg::scan_t                    in_data,
  input  bsm_pkg::ctrl_cmd_t                cmd,
  output bsm_pkg::ctrl_status_t             status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bsm_pkg::msg_t                     out_data
);
  import bsm_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int NW  = SB + 13;
  localparam int NSL = 9;

  // Slots in emission order
  localparam int SL_ALL_OFF = 0;
  localparam int SL_META    = 1;
  localparam int SL_OFF     = 2;
  localparam int SL_BREATH1 = 3;
  localparam int SL_BEND    = 4;
  localparam int SL_BREATH2 = 5;
  localparam int SL_X       = 6;
  localparam int SL_Y       = 7;
  localparam int SL_ON      = 8;

  function automatic logic [13:0] absdiff(input logic [13:0] a, input logic [13:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [13:0] snap_bend(input logic [13:0] v);
    logic [13:0] r;
    if (v <= 14'd683) r = 14'd0;
    else if (v <= 14'd2048) r = 14'd1365;
    else if (v <= 14'd3413) r = 14'd2731;
    else if (v <= 14'd4779) r = 14'd4096;
    else if (v <= 14'd6144) r = 14'd5461;
    else if (v <= 14'd7509) r = 14'd6827;
    else r = 14'd8191;
    return r;
  endfunction

  function automatic logic [7:0] key_note(input logic [3:0] k);
    logic [7:0] r;
    case (k)
      4'h0:    r = {1'b1, 7'd48};
      4'h1:    r = {1'b1, 7'd55};
      4'h3:    r = {1'b1, 7'd60};
      4'h7:    r = {1'b1, 7'd64};
      4'hF:    r = {1'b1, 7'd67};
      4'hE:    r = {1'b1, 7'd70};
      4'hC:    r = {1'b1, 7'd72};
      4'h8:    r = {1'b1, 7'd74};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Configuration registers
  logic        quantize_enable;
  logic [9:0]  breath_on_threshold, breath_full_scale;
  logic [9:0]  slide_first_pos, slide_last_pos, slide_no_touch;
  logic [12:0] bend_send_threshold;
  logic [15:0] cc_min_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantize_enable     <= 1'b0;
      breath_on_threshold <= 10'd60;
      breath_full_scale   <= 10'd500;
      slide_first_pos     <= 10'd144;
      slide_last_pos      <= 10'd350;
      slide_no_touch      <= 10'd1010;
      bend_send_threshold <= 13'd10;
      cc_min_interval     <= 16'd10;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_QUANTIZE:    quantize_enable     <= cfg_data[0];
        REG_BREATH_ON:   breath_on_threshold <= cfg_data[9:0];
        REG_BREATH_FULL: breath_full_scale   <= cfg_data[9:0];
        REG_SLIDE_FIRST: slide_first_pos     <= cfg_data[9:0];
        REG_SLIDE_LAST:  slide_last_pos      <= cfg_data[9:0];
        REG_SLIDE_NONE:  slide_no_touch      <= cfg_data[9:0];
        REG_BEND_THR:    bend_send_threshold <= cfg_data[12:0];
        REG_CC_INTERVAL: cc_min_interval     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted scan
  scan_t smp;
  always_ff @(posedge clk) begin
    if (cmd.capture) smp <= in_data;
  end

  // Clamp and form the division operands
  logic [9:0]    sl_hi, sl_c, br_c;
  logic [NW-1:0] bend_num, breath_num;
  logic [9:0]    bend_den, breath_den;
  logic [NW-1:0] bend_q, breath_q;
  logic          bend_busy, breath_busy;

  always_comb begin
    sl_hi      = (smp.slide_sample > slide_last_pos) ? slide_last_pos : smp.slide_sample;
    sl_c       = (sl_hi < slide_first_pos) ? slide_first_pos : sl_hi;
    br_c       = (smp.breath_sample > breath_full_scale) ? breath_full_scale
                                                         : smp.breath_sample;
    bend_num   = NW'(sl_c - slide_first_pos) * NW'(13'd8191);
    breath_num = NW'(10'(br_c - breath_on_threshold)) * NW'(7'd127);
    bend_den   = slide_last_pos - slide_first_pos;
    breath_den = breath_full_scale - breath_on_threshold;
  end

  bsm_div #(.NW(NW), .DW(10)) u_div_bend (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(bend_num), .den(bend_den), .busy(bend_busy), .quo(bend_q)
  );

  bsm_div #(.NW(NW), .DW(10)) u_div_breath (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(breath_num), .den(breath_den), .busy(breath_busy), .quo(breath_q)
  );

  // Note state
  logic        note_valid;
  logic [6:0]  sounding_note;
  logic [13:0] last_bend;
  logic [6:0]  last_volume, last_x, last_y;
  logic        meta_held;
  logic [3:0]  meta_keys;
  logic [30:0] last_cc_time;

  // Evaluate the scan
  logic        touched, have_note, time_ok;
  logic [13:0] pb_lin, pb;
  logic [6:0]  vol, note, mx, my;
  logic [7:0]  kn;
  logic [SB+6:0] x_prod, y_prod;
  logic        bend_ok, breath_ok, x_ok, y_ok;
  logic        c_off, c_start, c_change, c_update, c_send;
  logic [NSL-1:0] mask_eval;

  always_comb begin
    touched = smp.slide_sample <= slide_no_touch;
    pb_lin  = (slide_last_pos <= slide_first_pos) ? NEUTRAL_BEND
                                                  : NEUTRAL_BEND - 14'(bend_q[12:0]);
    pb      = quantize_enable ? snap_bend(pb_lin) : pb_lin;
    if (smp.breath_sample < breath_on_threshold) vol = 7'd0;
    else if (breath_full_scale <= breath_on_threshold) vol = 7'd127;
    else vol = breath_q[6:0];
    kn        = key_note(smp.overtone_keys);
    have_note = kn[7] || note_valid;
    note      = kn[7] ? kn[6:0] : sounding_note;
    x_prod    = (SB+7)'(smp.x_sample) * (SB+7)'(7'd127);
    y_prod    = (SB+7)'(smp.y_sample) * (SB+7)'(7'd127);
    mx        = x_prod[SB+6:SB];
    my        = y_prod[SB+6:SB];
    time_ok   = {1'b0, smp.time_ms} > (32'(last_cc_time) + 32'(cc_min_interval));
    bend_ok   = touched && (absdiff(last_bend, pb) > 14'(bend_send_threshold));
    breath_ok = absdiff(14'(last_volume), 14'(vol)) > 14'd1;
    x_ok      = absdiff(14'(last_x), 14'(mx)) > 14'd1;
    y_ok      = absdiff(14'(last_y), 14'(my)) > 14'd1;
    c_off     = note_valid && (vol == 7'd0);
    c_start   = !c_off && !note_valid && (vol != 7'd0) && have_note;
    c_change  = !c_off && note_valid && (note != sounding_note);
    c_update  = !c_off && !c_change && note_valid && time_ok;
    c_send    = c_start || c_change || c_update;
    mask_eval             = '0;
    mask_eval[SL_ALL_OFF] = smp.panic_pressed;
    mask_eval[SL_META]    = !smp.meta_pressed && meta_held;
    mask_eval[SL_OFF]     = c_off || c_change;
    mask_eval[SL_BREATH1] = c_start && breath_ok;
    mask_eval[SL_BEND]    = c_send && bend_ok;
    mask_eval[SL_BREATH2] = (c_change || c_update) && breath_ok;
    mask_eval[SL_X]       = c_send && x_ok;
    mask_eval[SL_Y]       = c_send && y_ok;
    mask_eval[SL_ON]      = c_start || c_change;
  end

  // Commit the state of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      note_valid    <= 1'b0;
      sounding_note <= '0;
      last_bend     <= NEUTRAL_BEND;
      last_volume   <= '0;
      last_x        <= '0;
      last_y        <= '0;
      meta_held     <= 1'b0;
      meta_keys     <= '0;
      last_cc_time  <= '0;
    end else if (cmd.eval) begin
      if (smp.meta_pressed) begin
        meta_held <= 1'b1;
        meta_keys <= smp.overtone_keys;
      end else begin
        meta_held <= 1'b0;
      end
      if (c_off) note_valid <= 1'b0;
      if (c_start) note_valid <= 1'b1;
      if (c_start || c_change) sounding_note <= note;
      if (c_update) last_cc_time <= smp.time_ms;
      if (mask_eval[SL_BEND]) last_bend <= pb;
      if (mask_eval[SL_BREATH1] || mask_eval[SL_BREATH2]) last_volume <= vol;
      if (mask_eval[SL_X]) last_x <= mx;
      if (mask_eval[SL_Y]) last_y <= my;
    end
  end

  // Message values of the scan
  logic [NSL-1:0] mask;
  logic [13:0]    m_pb;
  logic [6:0]     m_vol, m_mx, m_my, m_note, m_old_note, m_meta_note;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      m_pb        <= pb;
      m_vol       <= vol;
      m_mx        <= mx;
      m_my        <= my;
      m_note      <= note;
      m_old_note  <= sounding_note;
      m_meta_note <= 7'(meta_keys);
    end
  end

  // Pick the next pending slot
  logic [NSL-1:0] pick;
  logic           found;
  msg_t           msg;

  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < NSL; i++) begin
      if (mask[i] && !found) begin
        pick[i] = 1'b1;
        found   = 1'b1;
      end
    end
    msg      = '0;
    msg.last = (mask & ~pick) == '0;
    if (pick[SL_ALL_OFF]) begin
      msg.msg_kind = MSG_ALL_OFF;
      msg.channel  = 4'd1;
    end else if (pick[SL_META]) begin
      msg.msg_kind          = MSG_NOTE_ON;
      msg.channel           = 4'd1;
      msg.key_or_controller = m_meta_note;
      msg.value             = 14'd127;
    end else if (pick[SL_OFF]) begin
      msg.msg_kind          = MSG_NOTE_OFF;
      msg.key_or_controller = m_old_note;
    end else if (pick[SL_BREATH1] || pick[SL_BREATH2]) begin
      msg.msg_kind          = MSG_CC;
      msg.key_or_controller = CC_BREATH;
      msg.value             = 14'(m_vol);
    end else if (pick[SL_BEND]) begin
      msg.msg_kind = MSG_BEND;
      msg.value    = m_pb;
    end else if (pick[SL_X]) begin
      msg.msg_kind          = MSG_CC;
      msg.key_or_controller = CC_X;
      msg.value             = 14'(m_mx);
    end else if (pick[SL_Y]) begin
      msg.msg_kind          = MSG_CC;
      msg.key_or_controller = CC_Y;
      msg.value             = 14'(m_my);
    end else begin
      msg.msg_kind          = MSG_NOTE_ON;
      msg.key_or_controller = m_note;
      msg.value             = 14'd127;
    end
  end

  // Load the pending mask, drop each slot as it is sent
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.eval) begin
      mask <= mask_eval;
    end else if (cmd.emit) begin
      mask <= mask & ~pick;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data <= msg;
  end

  assign status.div_busy   = bend_busy || breath_busy;
  assign status.mask_empty = mask == '0;
  assign status.out_free   = !out_valid || !out_stall;
endmodule

@@ sv/breath_slide_midi_event_generator_core.sv @@
// ----------------------------------------------------------------------------
// breath_slide_midi_event_generator_core
// Turns sensor scans into MIDI note, bend and controller messages.
// ----------------------------------------------------------------------------
// Sequence: after a scan is accepted, a start step, the two serial mapping
//   divisions run side by side until both are done, evaluation, then the
//   messages, one per cycle while the output is not stalled.
// Scans: a new scan is accepted only once every message (0 to 8) of the
//   last one has been sent, later while the output is stalled.
// Reset: synchronous, restores register defaults, no note sounding.
module breath_slide_midi_event_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bsm_pkg::scan_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bsm_pkg::msg_t                  out_data
);
  import bsm_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  bsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  bsm_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_en(cfg_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .cmd(cmd), .status(status),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
